// ===== rtl/core/humidity_temp_frame_check_convert_core_macros.svh =====
// assertion macros shared by the checker of the frame check and convert core
// expects aclk and aresetn in the scope where a macro is used
`ifndef HUMIDITY_TEMP_FRAME_CHECK_CONVERT_CORE_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_CHECK_CONVERT_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define HDTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hdtc assertion failed");

// consequent checked in the cycle after the antecedent
`define HDTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hdtc assertion failed");

`endif

// ===== rtl/core/hdtc_pkg.sv =====
// shared types, constants and the crc-8 byte update for the frame check core
// no dependencies
package hdtc_pkg;

    localparam int DATA_W    = 8;
    localparam int RAW_W     = 16;
    localparam int LIMIT_W   = 11;
    localparam int READ_W    = 12;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT = 2'd1;

    // byte position within a frame, spare code never reached
    localparam logic [1:0] POS_HIGH  = 2'd0;
    localparam logic [1:0] POS_LOW   = 2'd1;
    localparam logic [1:0] POS_CRC   = 2'd2;
    localparam logic [1:0] POS_SPARE = 2'd3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd999;

    localparam logic [7:0]       CRC_POLY = 8'h31;
    localparam logic [RAW_W-1:0] RAW_MASK = 16'hfffc;

    // reading = (raw * scale - offset) / divisor, divisor 2^16 or 10 * 2^16
    localparam logic [14:0] HUM_SCALE   = 15'd1250;
    localparam logic [14:0] TEMP_SCALE  = 15'd17572;
    localparam logic [31:0] HUM_OFFSET  = 32'd3932160;
    localparam logic [31:0] TEMP_OFFSET = 32'd307036160;
    // ceil(2^16 / 10), exact for quotients up to 14 bits in the used range
    localparam logic [12:0] RECIP_TEN   = 13'd6554;

    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic             kind;
        logic             crc_ok;
    } conv_req_t;

    typedef struct packed {
        logic [READ_W-1:0] reading;
        logic              crc_ok;
        logic              clipped;
        logic              kind;
    } conv_res_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/hdtc_convert.sv =====
// three-stage conversion pipeline: scale multiply, offset and shift, divide and clamp
// depends on hdtc_pkg
module hdtc_convert (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  hdtc_pkg::conv_req_t             in_req,
    input  logic [hdtc_pkg::LIMIT_W-1:0]    hum_limit,
    input  logic [hdtc_pkg::LIMIT_W-1:0]    temp_limit,
    output logic                            out_valid,
    input  logic                            out_ready,
    output hdtc_pkg::conv_res_t             out_res
);
    import hdtc_pkg::*;

    logic        en_out, en3, en2;

    // stage 2: product
    logic        p2_vld_reg, p2_vld_next;
    logic [30:0] p2_prod_reg;
    logic        p2_kind_reg, p2_ok_reg;

    // stage 3: magnitude of the shifted difference
    logic        p3_vld_reg, p3_vld_next;
    logic [13:0] p3_mag_reg;
    logic        p3_neg_reg, p3_kind_reg, p3_ok_reg;

    logic        out_vld_reg, out_vld_next;
    conv_res_t   out_res_reg, out_res_next;

    logic [31:0] diff;
    logic [31:0] diff_abs;
    logic [26:0] tenth_prod;
    logic [10:0] quot;
    logic [LIMIT_W-1:0] lim;

    assign en_out   = !out_vld_reg || out_ready;
    assign en3      = !p3_vld_reg || en_out;
    assign en2      = !p2_vld_reg || en3;
    assign in_ready = en2;

    assign p2_vld_next  = en2 ? in_valid : p2_vld_reg;
    assign p3_vld_next  = en3 ? p2_vld_reg : p3_vld_reg;
    assign out_vld_next = en_out ? p3_vld_reg : out_vld_reg;

    assign diff     = {1'b0, p2_prod_reg} - (p2_kind_reg ? TEMP_OFFSET : HUM_OFFSET);
    assign diff_abs = diff[31] ? (32'd0 - diff) : diff;

    assign tenth_prod = 27'(p3_mag_reg) * 27'(RECIP_TEN);
    assign quot       = p3_kind_reg ? tenth_prod[26:16] : p3_mag_reg[10:0];
    assign lim        = p3_kind_reg ? temp_limit : hum_limit;

    always_comb begin
        out_res_next         = '0;
        out_res_next.crc_ok  = p3_ok_reg;
        out_res_next.kind    = p3_kind_reg;
        if (p3_ok_reg) begin
            if (p3_neg_reg) begin
                if (p3_kind_reg) begin
                    out_res_next.reading = READ_W'(12'd0 - {1'b0, quot});
                end else begin
                    // negative humidity floors at zero
                    out_res_next.clipped = (quot != 11'd0);
                end
            end else if (quot > lim) begin
                out_res_next.reading = {1'b0, lim};
                out_res_next.clipped = 1'b1;
            end else begin
                out_res_next.reading = {1'b0, quot};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            p2_vld_reg  <= p2_vld_next;
            p3_vld_reg  <= p3_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            p2_prod_reg <= 31'(in_req.raw) * 31'(in_req.kind ? TEMP_SCALE : HUM_SCALE);
            p2_kind_reg <= in_req.kind;
            p2_ok_reg   <= in_req.crc_ok;
        end
        if (en3) begin
            p3_mag_reg  <= diff_abs[29:16];
            p3_neg_reg  <= diff[31];
            p3_kind_reg <= p2_kind_reg;
            p3_ok_reg   <= p2_ok_reg;
        end
        if (en_out) begin
            out_res_reg <= out_res_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_res   = out_res_reg;

endmodule

// ===== rtl/core/humidity_temp_frame_check_convert_core.sv =====
// Sensor frame check and convert core.
// Input stream: one frame byte per request, high byte, low byte, then crc byte.
//   s_tdata[7:0] is the byte, s_tuser[0] marks the first byte of a frame and
//   s_tuser[1] gives the kind (0 humidity, 1 temperature), sampled on that byte.
//   A byte taken while no frame is open also starts a new frame.
// Output stream: one request per crc byte. m_tdata[11:0] holds the reading in
//   tenths (two's complement, 0 on crc failure), m_tuser holds crc_ok, clipped
//   and the frame kind. Data bytes produce no output.
// Config channel: cfg_index 0 writes the humidity limit, 1 the temperature
//   limit (11 bits each, both 999 after reset); other indexes are ignored.
// Throughput: one byte per cycle while s_tready is high. A crc byte's request
//   passes the s1 register and the multiply, offset and divide stages.
// Reset (aresetn low, synchronous) closes any open frame and empties the
//   pipeline. A stalled receiver holds the result; the pipeline keeps filling
//   and s_tready drops only once every stage holds a result.
// Depends on hdtc_pkg and hdtc_convert.
module humidity_temp_frame_check_convert_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // data_byte
    input  logic [1:0]                        s_tuser,   // frame_start, measure_kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // reading, zero pad
    output logic [2:0]                        m_tuser,   // crc_ok, clipped, reading_kind
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hdtc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hdtc_pkg::LIMIT_W-1:0]      cfg_data
);
    import hdtc_pkg::*;

    logic [LIMIT_W-1:0] hum_limit_reg, temp_limit_reg;

    logic [1:0]       pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic [RAW_W-1:0] raw_reg, raw_next;
    logic             kind_reg, kind_next;

    logic             s1_vld_reg, s1_vld_next;
    conv_req_t        s1_req_reg, s1_req_next;
    logic             s1_load;

    logic             accept;
    logic             cv_ready;
    conv_res_t        cv_res;

    // nothing is taken while reset is held
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = aresetn && (!s1_vld_reg || cv_ready);
    assign cfg_ready = aresetn;

    always_comb begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        raw_next    = raw_reg;
        kind_next   = kind_reg;
        s1_load     = 1'b0;
        s1_req_next = s1_req_reg;
        if (accept) begin
            if (s_tuser[0]) begin
                pos_next  = POS_LOW;
                crc_next  = crc8_update(8'd0, s_tdata);
                raw_next  = {s_tdata, 8'd0};
                kind_next = s_tuser[1];
            end else begin
                case (pos_reg)
                    POS_LOW: begin
                        pos_next = POS_CRC;
                        crc_next = crc8_update(crc_reg, s_tdata);
                        raw_next = {raw_reg[15:8], s_tdata};
                    end
                    POS_CRC: begin
                        pos_next           = POS_HIGH;
                        s1_load            = 1'b1;
                        s1_req_next.raw    = raw_reg & RAW_MASK;
                        s1_req_next.kind   = kind_reg;
                        s1_req_next.crc_ok = (crc_reg == s_tdata);
                    end
                    default: begin
                        // idle or unused position: byte opens a new frame
                        pos_next  = POS_LOW;
                        crc_next  = crc8_update(8'd0, s_tdata);
                        raw_next  = {s_tdata, 8'd0};
                        kind_next = s_tuser[1];
                    end
                endcase
            end
        end
    end

    assign s1_vld_next = s1_load ? 1'b1 : (cv_ready ? 1'b0 : s1_vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= POS_HIGH;
            s1_vld_reg     <= 1'b0;
            hum_limit_reg  <= LIMIT_RESET;
            temp_limit_reg <= LIMIT_RESET;
        end else begin
            pos_reg    <= pos_next;
            s1_vld_reg <= s1_vld_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_HUM_LIMIT:  hum_limit_reg  <= cfg_data;
                    CFG_TEMP_LIMIT: temp_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg    <= crc_next;
        raw_reg    <= raw_next;
        kind_reg   <= kind_next;
        s1_req_reg <= s1_req_next;
    end

    hdtc_convert u_convert (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s1_vld_reg),
        .in_ready   (cv_ready),
        .in_req     (s1_req_reg),
        .hum_limit  (hum_limit_reg),
        .temp_limit (temp_limit_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (cv_res)
    );

    assign m_tdata = {4'd0, cv_res.reading};
    assign m_tuser = {cv_res.kind, cv_res.clipped, cv_res.crc_ok};

endmodule

// ===== rtl/core/hdtc_checker.sv =====
// port-level checks for the frame check and convert core, bound to the top level
// depends on the assertion macros header
`include "humidity_temp_frame_check_convert_core_macros.svh"

module hdtc_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [15:0]                       m_tdata,
    input  logic [2:0]                        m_tuser
);

    // a stalled result holds
    `HDTC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // crc failure gives a zero, unclipped reading
    `HDTC_ASSERT_NOW(a_crc_fail_zero, m_tvalid && !m_tuser[0],
        m_tdata == 16'd0 && !m_tuser[1])

    // pad bits above the reading stay zero
    `HDTC_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[15:12] == 4'd0)

    // humidity never comes out negative
    `HDTC_ASSERT_NOW(a_hum_nonneg, m_tvalid && !m_tuser[2], !m_tdata[11])

endmodule

bind humidity_temp_frame_check_convert_core hdtc_checker u_hdtc_checker (.*);

// ===== tb/humidity_temp_frame_check_convert_core_test.sv =====
// self-checking testbench for the sensor frame check and convert core
// needs hdtc_pkg and the core; predicts every reading from its own frame model
`timescale 1ns / 1ps

module humidity_temp_frame_check_convert_core_test;
    import hdtc_pkg::*;

    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  TAIL_CYCLES  = 8;
    localparam int  REPORT_LINES = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [7:0]  POLY_31    = 8'h31;
    localparam logic [15:0] LOW_BITS   = 16'hfffc;
    localparam longint HUM_GAIN   = 1250;
    localparam longint HUM_BIAS   = 3932160;
    localparam longint HUM_DIV    = 65536;
    localparam longint TEMP_GAIN  = 17572;
    localparam longint TEMP_BIAS  = 307036160;
    localparam longint TEMP_DIV   = 655360;
    localparam logic [10:0] HUM_MAX  = 11'd1250;
    localparam logic [10:0] TEMP_MAX = 11'd1300;

    typedef struct packed {
        logic [11:0] reading;
        logic        crc_ok;
        logic        clipped;
        logic        kind;
    } reading_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;   // frame_start, measure_kind
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // reading, zero pad
    logic [2:0]  m_tuser;          // crc_ok, clipped, reading_kind
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LIMIT_W-1:0]   cfg_data  = '0;

    // frame model state
    logic [1:0]  frame_pos = POS_HIGH;
    logic [7:0]  crc_acc   = '0;
    logic [15:0] raw_hold  = '0;
    logic        kind_hold = 1'b0;
    logic [10:0] hum_lim   = 11'd999;
    logic [10:0] temp_lim  = 11'd999;

    reading_t expected_readings[$];
    reading_t want;

    bit idle_en    = 1'b1;
    int stall_left = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int bytes_sent = 0;
    int readings_checked = 0;
    int crc_fail_count = 0;
    int clip_count = 0;
    int limit_settings = 0;

    humidity_temp_frame_check_convert_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // crc-8, one message bit at a time, msb first
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0} ^ (fb ? POLY_31 : 8'h00);
        end
        return c;
    endfunction

    function automatic logic [7:0] frame_crc(input logic [15:0] raw);
        return crc8_next(crc8_next(8'h00, raw[15:8]), raw[7:0]);
    endfunction

    // raw values lean toward the ends, where the clamps and the sign change sit
    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 3))
            0: pick_raw = 16'($urandom_range(0, 16'h1fff));
            1: pick_raw = 16'($urandom_range(16'he000, 16'hffff));
            default: pick_raw = 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_LINES)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic predict_frame_byte(input logic [7:0] b, input logic st, input logic k);
        longint   r;
        longint   val;
        longint   lim;
        logic     ok;
        logic     clip;
        reading_t res;
        if (st || (frame_pos inside {POS_HIGH, POS_SPARE})) begin
            kind_hold = k;
            crc_acc   = crc8_next(8'h00, b);
            raw_hold  = {b, 8'h00};
            frame_pos = POS_LOW;
        end else if (frame_pos == POS_LOW) begin
            crc_acc   = crc8_next(crc_acc, b);
            raw_hold  = {raw_hold[15:8], b};
            frame_pos = POS_CRC;
        end else begin
            frame_pos = POS_HIGH;
            ok   = (crc_acc == b);
            clip = 1'b0;
            val  = 0;
            if (ok) begin
                r = longint'(raw_hold & LOW_BITS);
                if (!kind_hold) begin
                    val = (r * HUM_GAIN - HUM_BIAS) / HUM_DIV;
                    lim = longint'(hum_lim);
                    if (val < 0) begin
                        val  = 0;
                        clip = 1'b1;
                    end
                end else begin
                    val = (r * TEMP_GAIN - TEMP_BIAS) / TEMP_DIV;
                    lim = longint'(temp_lim);
                end
                if (val > lim) begin
                    val  = lim;
                    clip = 1'b1;
                end
            end else begin
                crc_fail_count++;
            end
            if (clip)
                clip_count++;
            res.reading = val[11:0];
            res.crc_ok  = ok;
            res.clipped = clip;
            res.kind    = kind_hold;
            expected_readings.push_back(res);
        end
    endtask

    // called at a falling edge; leaves s_tvalid high for a following request
    task automatic send_byte(input logic [7:0] b, input logic st, input logic k);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {k, st};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_frame_byte(b, st, k);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // kind on the low and crc bytes is noise the block must ignore
    task automatic send_frame(input logic k, input logic [15:0] raw, input logic mark,
                              input logic [7:0] crc_flip);
        send_byte(raw[15:8], mark, k);
        send_byte(raw[7:0], 1'b0, 1'($urandom));
        send_byte(frame_crc(raw) ^ crc_flip, 1'b0, 1'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_HUM_LIMIT)
            hum_lim = val;
        else if (idx == CFG_TEMP_LIMIT)
            temp_lim = val;
        @(negedge aclk);
    endtask

    task automatic set_limits(input logic [10:0] hum, input logic [10:0] temp);
        write_reg(CFG_HUM_LIMIT, hum);
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 11'($urandom));
        write_reg(CFG_TEMP_LIMIT, temp);
        cfg_valid <= 1'b0;
        limit_settings++;
        @(negedge aclk);
    endtask

    // sender pauses until every pending reading is out, then lets the pipeline empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (expected_readings.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic send_random_traffic(input int n_bytes);
        int stop_at;
        int pick;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(1'($urandom), pick_raw(), 1'($urandom), 8'h00);
            end else if (pick < 85) begin
                send_frame(1'($urandom), pick_raw(), 1'($urandom),
                           8'($urandom_range(1, 255)));
            end else if (pick < 95) begin
                // broken frame: one or two bytes, then whatever comes next
                send_byte(8'($urandom), 1'($urandom), 1'($urandom));
                if ($urandom_range(0, 1))
                    send_byte(8'($urandom), 1'b0, 1'($urandom));
            end else begin
                send_byte(8'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic test_directed_frames();
        send_frame(1'b0, 16'h0000, 1'b1, 8'h00);   // humidity below zero
        send_frame(1'b0, 16'hffff, 1'b0, 8'h00);   // humidity over limit, no start mark
        send_frame(1'b1, 16'h0000, 1'b1, 8'h00);   // coldest temperature
        send_frame(1'b1, 16'hffff, 1'b1, 8'h00);   // temperature over limit
        send_frame(1'b0, 16'h8000, 1'b1, 8'hff);   // crc failure
        // start mark after two bytes restarts the frame
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_frame(1'b1, 16'h6000, 1'b1, 8'h00);
        // start mark after one byte, status bits set in the raw value
        send_byte(8'h00, 1'b1, 1'b1);
        send_frame(1'b1, 16'h6543, 1'b1, 8'h00);
        wait_drained();
    endtask

    task automatic test_limit_extremes();
        set_limits(11'd0, 11'd0);
        send_frame(1'b0, 16'h8000, 1'b1, 8'h00);
        send_frame(1'b1, 16'h0000, 1'b1, 8'h00);
        send_frame(1'b1, 16'hffff, 1'b1, 8'h00);
        send_random_traffic(60);
        wait_drained();
        set_limits(HUM_MAX, TEMP_MAX);
        send_frame(1'b0, 16'hffff, 1'b1, 8'h00);
        send_frame(1'b1, 16'hffff, 1'b1, 8'h00);
        send_random_traffic(60);
        wait_drained();
    endtask

    task automatic test_random_frames();
        for (int chunk = 0; chunk < 10; chunk++) begin
            idle_en = ($urandom_range(0, 3) != 0);
            if (chunk % 3 == 2) begin
                wait_drained();
                set_limits(11'($urandom_range(0, HUM_MAX)), 11'($urandom_range(0, TEMP_MAX)));
            end
            send_random_traffic(100);
        end
        idle_en = 1'b1;
        wait_drained();
    endtask

    task automatic test_steady_stream();
        set_limits(11'd999, 11'd999);
        idle_en = 1'b0;
        send_random_traffic(200);
        wait_drained();
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch($sformatf("reading with none pending: tdata %h tuser %b",
                                          m_tdata, m_tuser));
            end else begin
                want = expected_readings.pop_front();
                if (m_tdata[11:0] !== want.reading)
                    report_mismatch($sformatf("reading %0d, want %0d",
                                              $signed(m_tdata[11:0]), $signed(want.reading)));
                if (m_tuser[0] !== want.crc_ok)
                    report_mismatch($sformatf("crc_ok %b, want %b", m_tuser[0], want.crc_ok));
                if (m_tuser[1] !== want.clipped)
                    report_mismatch($sformatf("clipped %b, want %b", m_tuser[1], want.clipped));
                if (m_tuser[2] !== want.kind)
                    report_mismatch($sformatf("kind %b, want %b", m_tuser[2], want.kind));
            end
            readings_checked++;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_frames();
        test_limit_extremes();
        test_random_frames();
        test_steady_stream();
        $display("covered %0d bytes, %0d readings checked, %0d crc failures, %0d clamped",
                 bytes_sent, readings_checked, crc_fail_count, clip_count);
        $display("limit settings used: %0d, mismatches: %0d", limit_settings, mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
